>>> src/dlpu_pkg.sv
// Package for the damped leapfrog particle update block.
// Holds the field widths, the register indexes, the pipeline depth and the item types.
// No dependencies.
`default_nettype none
package dlpu_pkg;
   localparam int VALUE_WIDTH = 32;
   localparam int MASS_WIDTH  = VALUE_WIDTH - 1;
   localparam int FRAC_BITS   = 16;
   localparam int DT_WIDTH    = 16;
   localparam int DAMP_WIDTH  = 17;
   localparam logic [DAMP_WIDTH-1:0] DAMP_ONE = DAMP_WIDTH'(1 << FRAC_BITS);
   localparam logic [DT_WIDTH-1:0] DT_RESET = DT_WIDTH'(66);
   // Quotient of (|fd| << 16) / m; |fd| needs one bit more than a value
   localparam int QUO_WIDTH   = VALUE_WIDTH + 1 + FRAC_BITS;
   // Lane registers up to its outputs: two front stages, one per quotient bit, three back
   localparam int LANE_LAT    = QUO_WIDTH + 5;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 17;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIME_STEP = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DAMPING   = CSR_INDEX_WIDTH'(1);

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] force_x;
      logic signed [VALUE_WIDTH-1:0] force_y;
      logic signed [VALUE_WIDTH-1:0] torque;
      logic signed [VALUE_WIDTH-1:0] vel_x;
      logic signed [VALUE_WIDTH-1:0] vel_y;
      logic signed [VALUE_WIDTH-1:0] spin;
      logic [MASS_WIDTH-1:0]         particle_mass;
      logic [MASS_WIDTH-1:0]         rot_inertia;
      logic [2:0]                    free_axes;
      logic                          first_step;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] new_vel_x;
      logic signed [VALUE_WIDTH-1:0] new_vel_y;
      logic signed [VALUE_WIDTH-1:0] new_spin;
      logic signed [VALUE_WIDTH-1:0] move_x;
      logic signed [VALUE_WIDTH-1:0] move_y;
      logic signed [VALUE_WIDTH-1:0] turn;
   } rsp_type;
endpackage
`default_nettype wire

>>> src/dlpu_lane.sv
// One axis of the particle update: damping, pipelined restoring divide, dt scaling.
// Depends on dlpu_pkg. Runs free every cycle; validity is tracked by the top level.
`default_nettype none
module dlpu_lane (
   input  wire logic                                  clock,
   input  wire logic signed [dlpu_pkg::VALUE_WIDTH-1:0] force_in,
   input  wire logic signed [dlpu_pkg::VALUE_WIDTH-1:0] vel_in,
   input  wire logic [dlpu_pkg::MASS_WIDTH-1:0]        mass_in,
   input  wire logic                                  free_in,
   input  wire logic                                  first_in,
   input  wire logic [dlpu_pkg::DT_WIDTH-1:0]          dt,
   input  wire logic [dlpu_pkg::DAMP_WIDTH-1:0]        damp_k,
   output logic signed [dlpu_pkg::VALUE_WIDTH-1:0]     new_vel,
   output logic signed [dlpu_pkg::VALUE_WIDTH-1:0]     move
);
   import dlpu_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int QW = QUO_WIDTH;
   localparam int PW = QW + DT_WIDTH + 1;
   localparam int SW = QW + 2;
   localparam int HW = QW - W;

   // stage 1: damping product
   logic [W-1:0]            fmag;
   logic [W+DAMP_WIDTH-1:0] dprod_ff;
   logic signed [W-1:0]     f1_ff, v1_ff;
   logic [MASS_WIDTH-1:0]   m1_ff;
   logic                    go1_ff, first1_ff;

   assign fmag = force_in[W-1] ? (~force_in + W'(1)) : force_in;

   always_ff @(posedge clock) begin
      dprod_ff  <= fmag * damp_k;
      f1_ff     <= force_in;
      v1_ff     <= vel_in;
      m1_ff     <= mass_in;
      go1_ff    <= free_in && (mass_in != '0);
      first1_ff <= first_in;
   end

   // stage 2: damped force, magnitude and sign; feeds divider slot 0
   logic [W-1:0]          damp;
   logic signed [W+1:0]   f_ext, d_ext, fd;
   logic [W+1:0]          fd_mag;
   logic                  v_pos;

   logic [QW-1:0]         num_ff   [QW+1];
   logic [MASS_WIDTH-1:0] rem_ff   [QW+1];
   logic [QW-1:0]         quo_ff   [QW+1];
   logic [MASS_WIDTH-1:0] m_ff     [QW+1];
   logic signed [W-1:0]   v_ff     [QW+1];
   logic                  neg_ff   [QW+1];
   logic                  go_ff    [QW+1];
   logic                  first_ff [QW+1];

   always_comb begin
      damp   = dprod_ff[FRAC_BITS +: W];
      f_ext  = {{2{f1_ff[W-1]}}, f1_ff};
      d_ext  = {2'b00, damp};
      v_pos  = !v1_ff[W-1] && (v1_ff != '0);
      fd     = v_pos ? (f_ext - d_ext) : (f_ext + d_ext);
      fd_mag = fd[W+1] ? (~fd + (W+2)'(1)) : fd;
   end

   always_ff @(posedge clock) begin
      num_ff[0]   <= {fd_mag[W:0], {FRAC_BITS{1'b0}}};
      rem_ff[0]   <= '0;
      quo_ff[0]   <= '0;
      m_ff[0]     <= m1_ff;
      v_ff[0]     <= v1_ff;
      neg_ff[0]   <= fd[W+1];
      go_ff[0]    <= go1_ff;
      first_ff[0] <= first1_ff;
   end

   // one quotient bit per stage, MSB first
   for (genvar k = 1; k <= QW; k++) begin : g_div
      logic [W-1:0] part;
      logic [W:0]   diff;
      logic         ge;
      always_comb begin
         part = {rem_ff[k-1], num_ff[k-1][QW-1]};
         diff = {1'b0, part} - {2'b00, m_ff[k-1]};
         ge   = !diff[W];
      end
      always_ff @(posedge clock) begin
         rem_ff[k]   <= ge ? diff[MASS_WIDTH-1:0] : part[MASS_WIDTH-1:0];
         quo_ff[k]   <= {quo_ff[k-1][QW-2:0], ge};
         num_ff[k]   <= {num_ff[k-1][QW-2:0], 1'b0};
         m_ff[k]     <= m_ff[k-1];
         v_ff[k]     <= v_ff[k-1];
         neg_ff[k]   <= neg_ff[k-1];
         go_ff[k]    <= go_ff[k-1];
         first_ff[k] <= first_ff[k-1];
      end
   end

   // M1: acceleration times dt, split in two partial products
   logic [W+DT_WIDTH-1:0]  plo_ff;
   logic [HW+DT_WIDTH-1:0] phi_ff;
   logic signed [W-1:0]    vm1_ff;
   logic                   negm1_ff, gom1_ff, firstm1_ff;

   always_ff @(posedge clock) begin
      plo_ff     <= quo_ff[QW][W-1:0] * dt;
      phi_ff     <= quo_ff[QW][QW-1:W] * dt;
      vm1_ff     <= v_ff[QW];
      negm1_ff   <= neg_ff[QW];
      gom1_ff    <= go_ff[QW];
      firstm1_ff <= first_ff[QW];
   end

   // M2: velocity update with saturation
   logic [PW-1:0]        prod;
   logic [QW-1:0]        dvm;
   logic signed [SW-1:0] vw, dw, sum;
   logic signed [W-1:0]  sat, nv_in;
   logic signed [W-1:0]  nv_ff;

   always_comb begin
      prod = PW'({phi_ff, {W{1'b0}}}) + PW'(plo_ff);
      dvm  = firstm1_ff ? prod[FRAC_BITS+1 +: QW] : prod[FRAC_BITS +: QW];
      vw   = {{(SW-W){vm1_ff[W-1]}}, vm1_ff};
      dw   = {2'b00, dvm};
      sum  = negm1_ff ? (vw - dw) : (vw + dw);
      if (sum[SW-1:W-1] == '0 || sum[SW-1:W-1] == '1) begin
         sat = sum[W-1:0];
      end else if (sum[SW-1]) begin
         sat = {1'b1, {(W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(W-1){1'b1}}};
      end
      nv_in = gom1_ff ? sat : vm1_ff;
   end

   always_ff @(posedge clock) begin
      nv_ff <= nv_in;
   end

   // M3: displacement product
   logic [W-1:0]          nv_mag;
   logic [W+DT_WIDTH-1:0] mvp_ff;
   logic signed [W-1:0]   nv3_ff;
   logic [W-1:0]          mvm;

   assign nv_mag = nv_ff[W-1] ? (~nv_ff + W'(1)) : nv_ff;

   always_ff @(posedge clock) begin
      mvp_ff <= nv_mag * dt;
      nv3_ff <= nv_ff;
   end

   assign mvm     = mvp_ff[FRAC_BITS +: W];
   assign new_vel = nv3_ff;
   assign move    = nv3_ff[W-1] ? (~mvm + W'(1)) : mvm;
endmodule
`default_nettype wire

>>> src/damped_leapfrog_particle_update_top.sv
// Top level of the damped leapfrog particle update: registers, item valid pipe, three lanes.
// Depends on dlpu_pkg and dlpu_lane.
//
//   channel  ports                         direction  transfer
//   input    start, busy, req              in         start && !busy
//   result   rsp_valid, rsp                out        one-cycle strobe
//   config   csr_valid, csr_ready,         in         csr_valid && csr_ready
//            csr_index, csr_wdata
//
// One item per cycle; each item passes the lane front stages and the 49-stage restoring divider,
// one quotient bit per stage, and then the back stages before its result is registered at the outputs.
// busy stays low: the pipe never stalls and the receiver takes every result.
// Synchronous reset clears the valid pipe and loads register defaults (dt 66, damping 0).
`default_nettype none
module damped_leapfrog_particle_update_top (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   output logic                                         busy,
   input  wire dlpu_pkg::req_type                       req,
   output logic                                         rsp_valid,
   output dlpu_pkg::rsp_type                            rsp,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [dlpu_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [dlpu_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import dlpu_pkg::*;

   logic [DT_WIDTH-1:0]   time_step_ff;
   logic [DAMP_WIDTH-1:0] damping_ff;
   logic [DAMP_WIDTH-1:0] damp_k;
   logic                  accept;
   logic [LANE_LAT-1:0]   vld_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff, rsp_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign damp_k    = (damping_ff > DAMP_ONE) ? DAMP_ONE : damping_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= DT_RESET;
         damping_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_TIME_STEP) begin
            time_step_ff <= csr_wdata[DT_WIDTH-1:0];
         end else if (csr_index == CSR_DAMPING) begin
            damping_ff <= csr_wdata[DAMP_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[LANE_LAT-2:0], accept};
         rsp_valid_ff <= vld_ff[LANE_LAT-1];
      end
   end

   dlpu_lane u_lane_x (
      .clock    (clock),
      .force_in (req.force_x),
      .vel_in   (req.vel_x),
      .mass_in  (req.particle_mass),
      .free_in  (req.free_axes[0]),
      .first_in (req.first_step),
      .dt       (time_step_ff),
      .damp_k   (damp_k),
      .new_vel  (rsp_in.new_vel_x),
      .move     (rsp_in.move_x)
   );

   dlpu_lane u_lane_y (
      .clock    (clock),
      .force_in (req.force_y),
      .vel_in   (req.vel_y),
      .mass_in  (req.particle_mass),
      .free_in  (req.free_axes[1]),
      .first_in (req.first_step),
      .dt       (time_step_ff),
      .damp_k   (damp_k),
      .new_vel  (rsp_in.new_vel_y),
      .move     (rsp_in.move_y)
   );

   dlpu_lane u_lane_r (
      .clock    (clock),
      .force_in (req.torque),
      .vel_in   (req.spin),
      .mass_in  (req.rot_inertia),
      .free_in  (req.free_axes[2]),
      .first_in (req.first_step),
      .dt       (time_step_ff),
      .damp_k   (damp_k),
      .new_vel  (rsp_in.new_spin),
      .move     (rsp_in.turn)
   );

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_reset_quiet: assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result strobe right after reset");
   a_item_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(vld_ff[LANE_LAT-1]))
      else $error("result strobe without a matching item");
   a_dt_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_index == CSR_TIME_STEP)
         |=> (time_step_ff == $past(csr_wdata[DT_WIDTH-1:0])))
      else $error("time step write lost");
   a_damp_clamp: assert property (@(posedge clock) disable iff (reset) damp_k <= DAMP_ONE)
      else $error("damping coefficient above one");
endmodule
`default_nettype wire

>>> bench/damped_leapfrog_particle_update_top_test.sv
// Testbench for damped_leapfrog_particle_update_top: random and directed particles,
// checked against an in-bench predictor through a small scoreboard class.
// Depends on dlpu_pkg and the block under test.
module damped_leapfrog_particle_update_top_test;
   import dlpu_pkg::*;

   localparam int LATENCY = LANE_LAT + 1;
   localparam int LIMIT   = 400000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   req_type req = '0;
   logic rsp_valid;
   rsp_type rsp;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_TIME_STEP;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   int errors = 0;
   int cycles = 0;
   logic quiet = 0;

   damped_leapfrog_particle_update_top u_top (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   class particle_scoreboard;
      logic [15:0] dt;
      logic [16:0] damping;
      rsp_type pending[$];

      function new();
         dt = 16'd66;
         damping = '0;
      endfunction

      function automatic logic [63:0] magnitude(longint v);
         return v < 0 ? 64'(-v) : 64'(v);
      endfunction

      // one axis: damped force, acceleration, velocity step and displacement
      function automatic void axis(logic signed [31:0] f_in, logic signed [31:0] v_in,
                                   logic [30:0] m, logic free_ax, logic first,
                                   output logic [31:0] nv_out, output logic [31:0] mv_out);
         longint f, v, fd, nv, damp;
         logic [63:0] d, am, dvm, mvm;
         f = f_in;
         v = v_in;
         d = damping > 17'd65536 ? 64'd65536 : 64'(damping);
         damp = longint'((d * magnitude(f)) >> 16);
         fd = v > 0 ? f - damp : f + damp;
         nv = v;
         if (free_ax && m != 0) begin
            am = (magnitude(fd) << 16) / 64'(m);
            dvm = (am * 64'(dt)) >> (first ? 17 : 16);
            nv = fd < 0 ? v - longint'(dvm) : v + longint'(dvm);
            if (nv > 64'sd2147483647) nv = 64'sd2147483647;
            if (nv < -64'sd2147483648) nv = -64'sd2147483648;
         end
         mvm = (magnitude(nv) * 64'(dt)) >> 16;
         nv_out = nv[31:0];
         mv_out = nv < 0 ? 32'(-longint'(mvm)) : mvm[31:0];
      endfunction

      function void note_particle(req_type r);
         rsp_type e;
         axis(r.force_x, r.vel_x, r.particle_mass, r.free_axes[0], r.first_step,
              e.new_vel_x, e.move_x);
         axis(r.force_y, r.vel_y, r.particle_mass, r.free_axes[1], r.first_step,
              e.new_vel_y, e.move_y);
         axis(r.torque, r.spin, r.rot_inertia, r.free_axes[2], r.first_step,
              e.new_spin, e.turn);
         pending.insert(pending.size(), e);
      endfunction

      function int check_update(rsp_type a);
         rsp_type e;
         int bad;
         bad = 0;
         if (pending.size() == 0) begin
            $error("result with no particle outstanding");
            return 1;
         end
         e = pending.pop_front();
         if (a.new_vel_x !== e.new_vel_x) begin
            $error("new_vel_x expected %h actual %h", e.new_vel_x, a.new_vel_x); bad++;
         end
         if (a.new_vel_y !== e.new_vel_y) begin
            $error("new_vel_y expected %h actual %h", e.new_vel_y, a.new_vel_y); bad++;
         end
         if (a.new_spin !== e.new_spin) begin
            $error("new_spin expected %h actual %h", e.new_spin, a.new_spin); bad++;
         end
         if (a.move_x !== e.move_x) begin
            $error("move_x expected %h actual %h", e.move_x, a.move_x); bad++;
         end
         if (a.move_y !== e.move_y) begin
            $error("move_y expected %h actual %h", e.move_y, a.move_y); bad++;
         end
         if (a.turn !== e.turn) begin
            $error("turn expected %h actual %h", e.turn, a.turn); bad++;
         end
         return bad;
      endfunction
   endclass

   particle_scoreboard board = new();

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) errors <= errors + board.check_update(rsp);
      if (!reset && start && !busy) board.note_particle(req);
      if (!reset && csr_valid && csr_ready) begin
         if (csr_index == CSR_TIME_STEP) board.dt = csr_wdata[15:0];
         else if (csr_index == CSR_DAMPING) board.damping = csr_wdata;
      end
      if (cycles > LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'(int'($urandom_range(0, 8)) - 4);
         3: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [30:0] pick_mass();
      case ($urandom_range(0, 5))
         0: return 31'h7FFF_FFFF;
         1: return 31'd1;
         2: return 31'($urandom_range(1, 200000));
         default: return 31'($urandom());
      endcase
   endfunction

   // start stays high after the accepting edge until drain() or a random gap in the next call lowers it
   task automatic send_particle(req_type r);
      if (!quiet) begin
         while ($urandom_range(0, 99) < 24) begin
            start <= 0;
            @(posedge clock);
         end
      end
      start <= 1;
      req <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic random_phase(int n);
      req_type r;
      for (int i = 0; i < n; i++) begin
         r.force_x = pick_value();
         r.force_y = pick_value();
         r.torque = pick_value();
         r.vel_x = pick_value();
         r.vel_y = pick_value();
         r.spin = pick_value();
         r.particle_mass = pick_mass();
         r.rot_inertia = pick_mass();
         r.free_axes = 3'($urandom());
         r.first_step = 1'($urandom());
         send_particle(r);
      end
   endtask

   initial begin
      req_type r;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, zero velocity, locked axes, first step, reset config
      r = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000,
            31'd1, 31'd1, 3'b111, 1'b0};
      send_particle(r);
      r.first_step = 1;
      send_particle(r);
      r.free_axes = 3'b000;
      send_particle(r);
      r = '{32'h0001_0000, -32'sh0001_0000, 32'h0002_0000, 32'd0, 32'd1, -32'sd1,
            31'h7FFF_FFFF, 31'h0001_0000, 3'b101, 1'b1};
      send_particle(r);
      drain();
      write_csr(CSR_DAMPING, 17'h1FFFF);
      write_csr(CSR_TIME_STEP, 17'h0FFFF);
      r = '{32'h4000_0000, -32'sh4000_0000, 32'h1234_5678, 32'd0, 32'd5, -32'sd5,
            31'h0000_8000, 31'h0000_0001, 3'b111, 1'b0};
      send_particle(r);
      r.free_axes = 3'b010;
      send_particle(r);
      random_phase(300);
      drain();

      write_csr(CSR_TIME_STEP, 17'd1);
      write_csr(CSR_DAMPING, 17'd0);
      random_phase(250);
      drain();

      write_csr(CSR_TIME_STEP, 17'($urandom_range(1, 65535)));
      write_csr(CSR_DAMPING, 17'd65536);
      quiet = 1;
      random_phase(350);
      quiet = 0;
      drain();

      write_csr(CSR_TIME_STEP, 17'd66);
      write_csr(CSR_DAMPING, 17'($urandom_range(0, 65536)));
      random_phase(400);
      drain();

      write_csr(CSR_TIME_STEP, 17'h1_0000);   // upper bit dropped: zero step
      write_csr(CSR_DAMPING, 17'd32768);
      random_phase(100);
      drain();

      write_csr(CSR_TIME_STEP, 17'($urandom_range(1, 65535)));
      write_csr(CSR_DAMPING, 17'($urandom()));
      write_csr(2'd3, 17'h1FFFF);            // unused index, ignored
      random_phase(340);
      drain();

      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
